FILE: sv/uvs_pkg.sv
// uvs_pkg: shared constants, register indexes and rounding helpers
// for the uv sphere vertex generator; no dependencies
`default_nettype none

package uvs_pkg;

   // angle unit constants, Q2.30 radians and Q30 magnitudes
   localparam logic [30:0]        HALFPI_Q30      = 31'd1686629713;
   localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
   localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;

   // pipeline shape
   localparam int TRIG_ITERATIONS = 16;
   localparam int DIV_STEPS       = 31;
   localparam int TEX_STEPS       = 17;
   localparam int ANGLE_LAT       = 3 + DIV_STEPS + TRIG_ITERATIONS;

   // register minimums
   localparam logic [9:0] SEG_MIN  = 10'd3;
   localparam logic [9:0] RING_MIN = 10'd2;

   // register reset values
   localparam logic [15:0] RADIUS_RESET    = 16'd256;
   localparam logic [9:0]  SEG_RESET       = 10'd16;
   localparam logic [9:0]  RING_RESET      = 10'd8;

   typedef enum logic [1:0] {
      CSR_RADIUS        = 2'd0,
      CSR_SEGMENT_COUNT = 2'd1,
      CSR_RING_COUNT    = 2'd2
   } csr_idx_type;

   // arctangent of 2^-i in Q30
   function automatic logic [31:0] atan_q30(input int i);
      logic [31:0] a;
      case (i)
         0:  a = 32'd843314857;
         1:  a = 32'd497837829;
         2:  a = 32'd263043837;
         3:  a = 32'd133525159;
         4:  a = 32'd67021687;
         5:  a = 32'd33543516;
         6:  a = 32'd16775851;
         7:  a = 32'd8388437;
         8:  a = 32'd4194283;
         9:  a = 32'd2097149;
         10: a = 32'd1048576;
         11: a = 32'd524288;
         12: a = 32'd262144;
         13: a = 32'd131072;
         14: a = 32'd65536;
         15: a = 32'd32768;
         16: a = 32'd16384;
         17: a = 32'd8192;
         18: a = 32'd4096;
         19: a = 32'd2048;
         20: a = 32'd1024;
         21: a = 32'd512;
         22: a = 32'd256;
         23: a = 32'd128;
         default: a = 32'd0;
      endcase
      return a;
   endfunction

   // Q30 to Q14, round half up, optional negate, clamp to +-1.0
   function automatic logic signed [15:0] unit_round(input logic signed [31:0] v,
                                                     input logic neg);
      logic signed [32:0] t;
      logic signed [17:0] r;
      t = {v[31], v} + 33'sd32768;
      r = {t[32], t[32:16]};
      if (neg) r = -r;
      if (r > 18'sd16384) r = 18'sd16384;
      else if (r < -18'sd16384) r = -18'sd16384;
      return r[15:0];
   endfunction

   // Q8.8 x Q30 product back to Q8.8, round half up, clamp
   function automatic logic signed [16:0] pos_round(input logic signed [49:0] p);
      logic signed [49:0] t;
      logic signed [19:0] r;
      t = p + 50'sd536870912;
      r = t[49:30];
      if (r > 20'sd65535) r = 20'sd65535;
      else if (r < -20'sd65535) r = -20'sd65535;
      return r[16:0];
   endfunction

endpackage

`default_nettype wire

FILE: sv/uvs_angle.sv
// uvs_angle: quadrant split, residual angle divider, pipelined cordic and
// texture coordinate divider for one angle; depends on uvs_pkg
`default_nettype none

module uvs_angle import uvs_pkg::*; (
   input  logic               clock,
   input  logic               adv,
   input  logic [11:0]        scaled,
   input  logic [9:0]         idx,
   input  logic [9:0]         cnt,
   output logic signed [31:0] cos_o,
   output logic signed [31:0] sin_o,
   output logic [16:0]        tex_o
);

   // stage a: quadrant and remainder by three compare-subtract steps
   logic [1:0]  a_q_ff;
   logic [9:0]  a_rem_ff;
   logic        a_zero_ff;
   logic [26:0] a_tn_ff;
   logic [11:0] a_r_in;
   logic [2:0]  a_q_in;

   always_comb begin
      logic [11:0] d;
      a_r_in = scaled;
      a_q_in = 3'd0;
      for (int b = 2; b >= 0; b--) begin
         d = {2'b00, cnt} << b;
         if (a_r_in >= d) begin
            a_r_in    = a_r_in - d;
            a_q_in[b] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_q_ff    <= a_q_in[1:0];
         a_rem_ff  <= a_r_in[9:0];
         a_zero_ff <= (a_r_in == 12'd0);
         a_tn_ff   <= {idx, 17'd0} | {17'd0, cnt};
      end
   end

   // divider stages, index 0 holds the residual product
   logic [9:0]  dr_ff    [0:DIV_STEPS];
   logic [30:0] dm_ff    [0:DIV_STEPS];
   logic [30:0] dq_ff    [0:DIV_STEPS];
   logic [10:0] tr_ff    [0:DIV_STEPS];
   logic [16:0] tn_ff    [0:DIV_STEPS];
   logic [16:0] tq_ff    [0:DIV_STEPS];
   logic [1:0]  dquad_ff [0:DIV_STEPS];
   logic        dzero_ff [0:DIV_STEPS];
   logic [40:0] m_in;

   assign m_in = a_rem_ff * HALFPI_Q30;

   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[0]    <= m_in[40:31];
         dm_ff[0]    <= m_in[30:0];
         dq_ff[0]    <= 31'd0;
         tr_ff[0]    <= {1'b0, a_tn_ff[26:17]};
         tn_ff[0]    <= a_tn_ff[16:0];
         tq_ff[0]    <= 17'd0;
         dquad_ff[0] <= a_q_ff;
         dzero_ff[0] <= a_zero_ff;
      end
   end

   genvar k;
   generate
      for (k = 1; k <= DIV_STEPS; k++) begin : g_div
         logic [10:0] r2;
         logic [9:0]  r_in;
         logic        b_in;
         logic [10:0] t_in;
         logic [16:0] tq_in;

         // one quotient bit of the residual angle
         always_comb begin
            r2 = {dr_ff[k-1], dm_ff[k-1][DIV_STEPS-k]};
            if (r2 >= {1'b0, cnt}) begin
               r_in = 10'(r2 - {1'b0, cnt});
               b_in = 1'b1;
            end else begin
               r_in = r2[9:0];
               b_in = 1'b0;
            end
         end

         // one quotient bit of the texture coordinate
         if (k <= TEX_STEPS) begin : g_tex
            logic [11:0] t2;
            always_comb begin
               t2 = {tr_ff[k-1], tn_ff[k-1][TEX_STEPS-k]};
               if (t2 >= {1'b0, cnt, 1'b0}) begin
                  t_in  = 11'(t2 - {1'b0, cnt, 1'b0});
                  tq_in = {tq_ff[k-1][15:0], 1'b1};
               end else begin
                  t_in  = t2[10:0];
                  tq_in = {tq_ff[k-1][15:0], 1'b0};
               end
            end
         end else begin : g_hold
            assign t_in  = tr_ff[k-1];
            assign tq_in = tq_ff[k-1];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               dr_ff[k]    <= r_in;
               dm_ff[k]    <= dm_ff[k-1];
               dq_ff[k]    <= {dq_ff[k-1][29:0], b_in};
               tr_ff[k]    <= t_in;
               tn_ff[k]    <= tn_ff[k-1];
               tq_ff[k]    <= tq_in;
               dquad_ff[k] <= dquad_ff[k-1];
               dzero_ff[k] <= dzero_ff[k-1];
            end
         end
      end
   endgenerate

   // cordic rotation stages
   logic signed [31:0] cx_ff    [1:TRIG_ITERATIONS];
   logic signed [31:0] cy_ff    [1:TRIG_ITERATIONS];
   logic signed [31:0] cz_ff    [1:TRIG_ITERATIONS];
   logic [1:0]         cquad_ff [1:TRIG_ITERATIONS];
   logic               czero_ff [1:TRIG_ITERATIONS];
   logic [16:0]        ctex_ff  [1:TRIG_ITERATIONS];

   genvar c;
   generate
      for (c = 1; c <= TRIG_ITERATIONS; c++) begin : g_cordic
         localparam int I = c - 1;
         localparam logic signed [31:0] ATAN = $signed(atan_q30(I));
         logic signed [31:0] px, py, pz, dx, dy;
         logic [1:0]         pq;
         logic               pzero;
         logic [16:0]        ptex;

         if (c == 1) begin : g_first
            assign px    = CORDIC_GAIN_Q30;
            assign py    = 32'sd0;
            assign pz    = $signed({1'b0, dq_ff[DIV_STEPS]});
            assign pq    = dquad_ff[DIV_STEPS];
            assign pzero = dzero_ff[DIV_STEPS];
            assign ptex  = tq_ff[DIV_STEPS];
         end else begin : g_next
            assign px    = cx_ff[c-1];
            assign py    = cy_ff[c-1];
            assign pz    = cz_ff[c-1];
            assign pq    = cquad_ff[c-1];
            assign pzero = czero_ff[c-1];
            assign ptex  = ctex_ff[c-1];
         end

         assign dx = py >>> I;
         assign dy = px >>> I;

         always_ff @(posedge clock) begin
            if (adv) begin
               if (!pz[31]) begin
                  cx_ff[c] <= px - dx;
                  cy_ff[c] <= py + dy;
                  cz_ff[c] <= pz - ATAN;
               end else begin
                  cx_ff[c] <= px + dx;
                  cy_ff[c] <= py - dy;
                  cz_ff[c] <= pz + ATAN;
               end
               cquad_ff[c] <= pq;
               czero_ff[c] <= pzero;
               ctex_ff[c]  <= ptex;
            end
         end
      end
   endgenerate

   // exact axis values and quadrant rotation
   logic signed [31:0] bx, by, cos_ff, sin_ff;
   logic signed [31:0] cos_in, sin_in;
   logic [16:0]        tex_ff;

   assign bx = czero_ff[TRIG_ITERATIONS] ? ONE_Q30 : cx_ff[TRIG_ITERATIONS];
   assign by = czero_ff[TRIG_ITERATIONS] ? 32'sd0  : cy_ff[TRIG_ITERATIONS];

   always_comb begin
      case (cquad_ff[TRIG_ITERATIONS])
         2'd1:    begin cos_in = -by; sin_in = bx;  end
         2'd2:    begin cos_in = -bx; sin_in = -by; end
         2'd3:    begin cos_in = by;  sin_in = -bx; end
         default: begin cos_in = bx;  sin_in = by;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
         tex_ff <= ctex_ff[TRIG_ITERATIONS];
      end
   end

   assign cos_o = cos_ff;
   assign sin_o = sin_ff;
   assign tex_o = tex_ff;

endmodule

`default_nettype wire

FILE: sv/uv_sphere_vertex_gen_top.sv
// uv_sphere_vertex_gen_top: uv sphere vertex pipeline, config registers,
// output scaling; depends on uvs_pkg and uvs_angle
//
// Takes one (ring, segment) grid point per clock and returns the vertex
// position (Q8.8), unit normal, longitude tangent (Q1.14) and texture
// coordinate (Q1.16). The pipeline holds 55 register stages: an input
// register, 50 stages per angle (a quadrant split, a residual product
// register, a 31 stage residual divider that also carries the 17 bit
// texture divider, 16 cordic stages and a quadrant rotation) and 4 stages
// of products and rounding. A new transaction is taken every cycle; the
// whole pipeline holds while the result stage is stalled. Configuration
// must only be written while the pipeline is empty.
`default_nettype none

module uv_sphere_vertex_gen_top import uvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [9:0]         req_ring_index,
   input  logic [9:0]         req_segment_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic signed [15:0] rsp_tangent_x,
   output logic signed [15:0] rsp_tangent_y,
   output logic               rsp_out_of_range,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   logic adv;

   // pipeline advances unless the result stage is held
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // config registers
   logic [15:0] radius_ff;
   logic [9:0]  seg_count_ff, ring_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         seg_count_ff  <= SEG_RESET;
         ring_count_ff <= RING_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_RADIUS:        radius_ff <= csr_wdata;
            CSR_SEGMENT_COUNT: seg_count_ff <= (csr_wdata[9:0] < SEG_MIN) ?
                                               SEG_MIN : csr_wdata[9:0];
            CSR_RING_COUNT:    ring_count_ff <= (csr_wdata[9:0] < RING_MIN) ?
                                                RING_MIN : csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // input register
   logic       in_valid_ff;
   logic [9:0] in_ring_ff, in_seg_ff;
   logic       in_oor;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (adv) in_valid_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ring_ff <= req_ring_index;
         in_seg_ff  <= req_segment_index;
      end
   end

   assign in_oor = (in_ring_ff > ring_count_ff) || (in_seg_ff > seg_count_ff);

   // valid and range flag travel beside the angle units
   logic [ANGLE_LAT-1:0] vd_ff, od_ff;

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= '0;
      else if (adv) vd_ff <= {vd_ff[ANGLE_LAT-2:0], in_valid_ff};
   end

   always_ff @(posedge clock) begin
      if (adv) od_ff <= {od_ff[ANGLE_LAT-2:0], in_oor};
   end

   // sector and polar angle units
   logic signed [31:0] cp, sp, ct, st;
   logic [16:0]        tex_u, tex_v;

   uvs_angle u_sector (
      .clock  (clock),
      .adv    (adv),
      .scaled ({in_seg_ff, 2'b00}),
      .idx    (in_seg_ff),
      .cnt    (seg_count_ff),
      .cos_o  (cp),
      .sin_o  (sp),
      .tex_o  (tex_u)
   );

   uvs_angle u_polar (
      .clock  (clock),
      .adv    (adv),
      .scaled ({1'b0, in_ring_ff, 1'b0}),
      .idx    (in_ring_ff),
      .cnt    (ring_count_ff),
      .cos_o  (ct),
      .sin_o  (st),
      .tex_o  (tex_v)
   );

   // p1: direction products
   logic               p1_valid_ff, p1_oor_ff;
   logic signed [63:0] p1_px_ff, p1_py_ff;
   logic signed [31:0] p1_ct_ff, p1_cp_ff, p1_sp_ff;
   logic [16:0]        p1_u_ff, p1_v_ff;

   // p2: rounded direction
   logic               p2_valid_ff, p2_oor_ff;
   logic signed [31:0] p2_dx_ff, p2_dy_ff, p2_dz_ff, p2_cp_ff, p2_sp_ff;
   logic [16:0]        p2_u_ff, p2_v_ff;
   logic signed [63:0] p2_rx_in, p2_ry_in;

   // p3: radius products and unit rounding
   logic               p3_valid_ff, p3_oor_ff;
   logic signed [49:0] p3_px_ff, p3_py_ff, p3_pz_ff;
   logic signed [15:0] p3_nx_ff, p3_ny_ff, p3_nz_ff, p3_tx_ff, p3_ty_ff;
   logic [16:0]        p3_u_ff, p3_v_ff;
   logic signed [16:0] rad_s;

   // p4: result register
   logic               out_valid_ff, out_oor_ff;
   logic signed [16:0] out_px_ff, out_py_ff, out_pz_ff;
   logic signed [15:0] out_nx_ff, out_ny_ff, out_nz_ff, out_tx_ff, out_ty_ff;
   logic [16:0]        out_u_ff, out_v_ff;

   assign p2_rx_in = p1_px_ff + 64'sd536870912;
   assign p2_ry_in = p1_py_ff + 64'sd536870912;
   assign rad_s    = $signed({1'b0, radius_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff  <= vd_ff[ANGLE_LAT-1];
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         out_valid_ff <= p3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_oor_ff <= od_ff[ANGLE_LAT-1];
         p1_px_ff  <= st * cp;
         p1_py_ff  <= st * sp;
         p1_ct_ff  <= ct;
         p1_cp_ff  <= cp;
         p1_sp_ff  <= sp;
         p1_u_ff   <= tex_u;
         p1_v_ff   <= tex_v;

         p2_oor_ff <= p1_oor_ff;
         p2_dx_ff  <= p2_rx_in[61:30];
         p2_dy_ff  <= p2_ry_in[61:30];
         p2_dz_ff  <= p1_ct_ff;
         p2_cp_ff  <= p1_cp_ff;
         p2_sp_ff  <= p1_sp_ff;
         p2_u_ff   <= p1_u_ff;
         p2_v_ff   <= p1_v_ff;

         p3_oor_ff <= p2_oor_ff;
         p3_px_ff  <= 50'(rad_s * p2_dx_ff);
         p3_py_ff  <= 50'(rad_s * p2_dy_ff);
         p3_pz_ff  <= 50'(rad_s * p2_dz_ff);
         p3_nx_ff  <= unit_round(p2_dx_ff, 1'b0);
         p3_ny_ff  <= unit_round(p2_dy_ff, 1'b0);
         p3_nz_ff  <= unit_round(p2_dz_ff, 1'b0);
         p3_tx_ff  <= unit_round(p2_sp_ff, 1'b1);
         p3_ty_ff  <= unit_round(p2_cp_ff, 1'b0);
         p3_u_ff   <= p2_u_ff;
         p3_v_ff   <= p2_v_ff;

         // out of range transactions read as all zero apart from the range flag
         out_oor_ff <= p3_oor_ff;
         out_px_ff  <= p3_oor_ff ? 17'sd0 : pos_round(p3_px_ff);
         out_py_ff  <= p3_oor_ff ? 17'sd0 : pos_round(p3_py_ff);
         out_pz_ff  <= p3_oor_ff ? 17'sd0 : pos_round(p3_pz_ff);
         out_nx_ff  <= p3_oor_ff ? 16'sd0 : p3_nx_ff;
         out_ny_ff  <= p3_oor_ff ? 16'sd0 : p3_ny_ff;
         out_nz_ff  <= p3_oor_ff ? 16'sd0 : p3_nz_ff;
         out_tx_ff  <= p3_oor_ff ? 16'sd0 : p3_tx_ff;
         out_ty_ff  <= p3_oor_ff ? 16'sd0 : p3_ty_ff;
         out_u_ff   <= p3_oor_ff ? 17'd0 : p3_u_ff;
         out_v_ff   <= p3_oor_ff ? 17'd0 : p3_v_ff;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_pos_x        = out_px_ff;
   assign rsp_pos_y        = out_py_ff;
   assign rsp_pos_z        = out_pz_ff;
   assign rsp_norm_x       = out_nx_ff;
   assign rsp_norm_y       = out_ny_ff;
   assign rsp_norm_z       = out_nz_ff;
   assign rsp_tex_u        = out_u_ff;
   assign rsp_tex_v        = out_v_ff;
   assign rsp_tangent_x    = out_tx_ff;
   assign rsp_tangent_y    = out_ty_ff;
   assign rsp_out_of_range = out_oor_ff;

endmodule

`default_nettype wire

FILE: verif/uvs_checker.sv
// uvs_checker: watches the uv sphere vertex channels, predicts each vertex
// and compares it with the result stream; depends on uvs_pkg
`timescale 1ns / 100ps
`default_nettype none

module uvs_checker import uvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [9:0]         req_ring_index,
   input  logic [9:0]         req_segment_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [16:0] rsp_pos_x,
   input  logic signed [16:0] rsp_pos_y,
   input  logic signed [16:0] rsp_pos_z,
   input  logic signed [15:0] rsp_norm_x,
   input  logic signed [15:0] rsp_norm_y,
   input  logic signed [15:0] rsp_norm_z,
   input  logic [16:0]        rsp_tex_u,
   input  logic [16:0]        rsp_tex_v,
   input  logic signed [15:0] rsp_tangent_x,
   input  logic signed [15:0] rsp_tangent_y,
   input  logic               rsp_out_of_range,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [16:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [16:0]        tex_u, tex_v;
      logic signed [15:0] tan_x, tan_y;
      logic               oor;
   } vertex_type;

   vertex_type  vertex_q[$];
   logic [15:0] radius_r;
   logic [9:0]  segs_r, rings_r;

   // floor shift on 64 bit signed values
   function automatic longint asr(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint rnd(input longint v, input int s);
      return asr(v + (longint'(1) << (s - 1)), s);
   endfunction

   function automatic longint sat(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // cosine and sine in Q30 of q quarter turns plus rem/div of a quarter turn
   task automatic angle_cs(input longint unsigned q, input longint unsigned rem,
                           input longint unsigned div, output longint c,
                           output longint s);
      longint x, y, z, t, dx, dy;
      longint unsigned zu;
      x = ONE_Q30;
      y = 0;
      if (rem != 0) begin
         zu = (rem * longint'(HALFPI_Q30)) / div;
         z = zu;
         x = CORDIC_GAIN_Q30;
         for (int i = 0; i < TRIG_ITERATIONS && i < 24; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(atan_q30(i));
            end else begin
               x += dx; y -= dy; z += longint'(atan_q30(i));
            end
         end
      end
      case (q & 3)
         1: begin t = x; x = -y; y = t; end
         2: begin x = -x; y = -y; end
         3: begin t = x; x = y; y = -t; end
         default: ;
      endcase
      c = x;
      s = y;
   endtask

   task automatic predict_vertex(input logic [9:0] ring, input logic [9:0] seg,
                                 output vertex_type v);
      longint unsigned r, sg, rs, ss;
      longint cp, sp, ct, st, d0, d1, d2, rad;
      v = '0;
      r = ring; sg = seg; rs = rings_r; ss = segs_r;
      if (r > rs || sg > ss) begin
         v.oor = 1'b1;
         return;
      end
      angle_cs((4 * sg) / ss, (4 * sg) % ss, ss, cp, sp);
      angle_cs((2 * r) / rs, (2 * r) % rs, rs, ct, st);
      d0 = rnd(st * cp, 30);
      d1 = rnd(st * sp, 30);
      d2 = ct;
      rad = radius_r;
      v.pos_x  = 17'(sat(rnd(rad * d0, 30), 65535));
      v.pos_y  = 17'(sat(rnd(rad * d1, 30), 65535));
      v.pos_z  = 17'(sat(rnd(rad * d2, 30), 65535));
      v.norm_x = 16'(sat(rnd(d0, 16), 16384));
      v.norm_y = 16'(sat(rnd(d1, 16), 16384));
      v.norm_z = 16'(sat(rnd(d2, 16), 16384));
      v.tex_u  = 17'((sg * 131072 + ss) / (2 * ss));
      v.tex_v  = 17'((r * 131072 + rs) / (2 * rs));
      v.tan_x  = 16'(sat(-rnd(sp, 16), 16384));
      v.tan_y  = 16'(sat(rnd(cp, 16), 16384));
   endtask

   function automatic logic [9:0] clamp_count(input logic [9:0] v,
                                              input logic [9:0] lo);
      return (v < lo) ? lo : v;
   endfunction

   // register shadow
   always @(posedge clock) begin
      if (reset) begin
         radius_r <= RADIUS_RESET;
         segs_r   <= SEG_RESET;
         rings_r  <= RING_RESET;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_RADIUS:        radius_r <= csr_wdata;
            CSR_SEGMENT_COUNT: segs_r   <= clamp_count(csr_wdata[9:0], SEG_MIN);
            CSR_RING_COUNT:    rings_r  <= clamp_count(csr_wdata[9:0], RING_MIN);
            default: ;
         endcase
      end
   end

   // predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      vertex_type exp_v, act_v;
      if (reset) begin
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_vertex(req_ring_index, req_segment_index, exp_v);
            vertex_q = {vertex_q, exp_v};
         end
         if (rsp_valid && !rsp_stall) begin
            act_v = '{rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_norm_x, rsp_norm_y,
                      rsp_norm_z, rsp_tex_u, rsp_tex_v, rsp_tangent_x,
                      rsp_tangent_y, rsp_out_of_range};
            if (vertex_q.size() == 0) begin
               $display("%0t: unexpected result transaction %h", $time, act_v);
               fail_count++;
            end else begin
               exp_v = vertex_q.pop_front();
               if (exp_v.pos_x != act_v.pos_x)
                  $display("%0t: pos_x exp %0d got %0d", $time, exp_v.pos_x, act_v.pos_x);
               if (exp_v.pos_y != act_v.pos_y)
                  $display("%0t: pos_y exp %0d got %0d", $time, exp_v.pos_y, act_v.pos_y);
               if (exp_v.pos_z != act_v.pos_z)
                  $display("%0t: pos_z exp %0d got %0d", $time, exp_v.pos_z, act_v.pos_z);
               if (exp_v.norm_x != act_v.norm_x)
                  $display("%0t: norm_x exp %0d got %0d", $time, exp_v.norm_x, act_v.norm_x);
               if (exp_v.norm_y != act_v.norm_y)
                  $display("%0t: norm_y exp %0d got %0d", $time, exp_v.norm_y, act_v.norm_y);
               if (exp_v.norm_z != act_v.norm_z)
                  $display("%0t: norm_z exp %0d got %0d", $time, exp_v.norm_z, act_v.norm_z);
               if (exp_v.tex_u != act_v.tex_u)
                  $display("%0t: tex_u exp %0d got %0d", $time, exp_v.tex_u, act_v.tex_u);
               if (exp_v.tex_v != act_v.tex_v)
                  $display("%0t: tex_v exp %0d got %0d", $time, exp_v.tex_v, act_v.tex_v);
               if (exp_v.tan_x != act_v.tan_x)
                  $display("%0t: tangent_x exp %0d got %0d", $time, exp_v.tan_x, act_v.tan_x);
               if (exp_v.tan_y != act_v.tan_y)
                  $display("%0t: tangent_y exp %0d got %0d", $time, exp_v.tan_y, act_v.tan_y);
               if (exp_v.oor != act_v.oor)
                  $display("%0t: out_of_range exp %0d got %0d", $time, exp_v.oor, act_v.oor);
               if (exp_v != act_v) fail_count++;
            end
         end
      end
      pending_count = vertex_q.size();
   end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// testbench: stimulus and verdict for uv_sphere_vertex_gen_top; depends on
// uvs_pkg, the block and uvs_checker
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import uvs_pkg::*;

   localparam int LATENCY = 60;
   localparam int IDLE_LIMIT = 5000;

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, rsp_stall = 1'b0, csr_wr_en = 1'b0;
   logic [9:0] req_ring_index = '0, req_segment_index = '0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic req_stall, rsp_valid, rsp_out_of_range;
   logic signed [16:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic signed [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_tangent_x, rsp_tangent_y;
   logic [16:0] rsp_tex_u, rsp_tex_v;
   int fail_count, pending_count, idle_cycles;
   logic hold_off = 1'b0;
   logic [9:0] segs_now = SEG_RESET, rings_now = RING_RESET;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   uv_sphere_vertex_gen_top uut (.*);
   uvs_checker chk (.*);

   // receiver stall pattern, with a long hold-off on request
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 2);
         repeat ($urandom_range(5, 60)) begin
            @(negedge clock);
            if (hold_off) rsp_stall <= 1'b1;
            else if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      end
   end

   // watchdog on accepted transactions
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL uv_sphere_vertex_gen_top");
         $finish;
      end
   end

   task automatic send_vertex(input logic [9:0] ring, input logic [9:0] seg);
      req_ring_index <= ring;
      req_segment_index <= seg;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // sender: random gaps between bursts
   task automatic maybe_gap();
      if ($urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY) @(negedge clock);
   endtask

   // one write with the enable high, then the enable is dropped again
   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      if (idx == CSR_SEGMENT_COUNT) segs_now = (val[9:0] < SEG_MIN) ? SEG_MIN : val[9:0];
      if (idx == CSR_RING_COUNT) rings_now = (val[9:0] < RING_MIN) ? RING_MIN : val[9:0];
   endtask

   // mostly in-range grid points, some beyond the counts
   task automatic random_vertices(input int n);
      logic [9:0] r, s;
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) begin
            r = 10'($urandom_range(0, 1023));
            s = 10'($urandom_range(0, 1023));
         end else begin
            r = 10'($urandom_range(0, rings_now));
            s = 10'($urandom_range(0, segs_now));
         end
         send_vertex(r, s);
         maybe_gap();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: poles, seams, equator, index beyond counts, max fields
      send_vertex(0, 0);
      send_vertex(8, 16);
      send_vertex(4, 4);
      send_vertex(4, 8);
      send_vertex(4, 12);
      send_vertex(2, 3);
      send_vertex(9, 0);
      send_vertex(0, 17);
      send_vertex(10'h3ff, 10'h3ff);
      send_vertex(8, 0);
      send_vertex(5, 11);
      drain();

      // zero radius
      write_reg(CSR_RADIUS, 16'd0);
      send_vertex(3, 5);
      send_vertex(0, 0);
      drain();

      // largest radius and counts
      write_reg(CSR_RADIUS, 16'hffff);
      write_reg(CSR_SEGMENT_COUNT, 16'd1023);
      write_reg(CSR_RING_COUNT, 16'd1023);
      send_vertex(511, 0);
      send_vertex(1023, 1023);
      send_vertex(10'h2aa, 10'h155);
      random_vertices(150);
      drain();

      // clamped minimum counts
      write_reg(CSR_SEGMENT_COUNT, 16'd0);
      write_reg(CSR_RING_COUNT, 16'hfc01);
      write_reg(CSR_RADIUS, 16'h5a5a);
      send_vertex(1, 1);
      send_vertex(2, 3);
      random_vertices(150);

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(negedge clock);
            hold_off = 1'b0;
         end
         random_vertices(100);
      join
      drain();

      // assorted settings
      for (int k = 0; k < 5; k++) begin
         write_reg(CSR_RADIUS, 16'($urandom_range(0, 65535)));
         write_reg(CSR_SEGMENT_COUNT, 16'($urandom_range(0, 65535)));
         write_reg(CSR_RING_COUNT, 16'($urandom_range(0, 65535)));
         if (k < 2) begin
            write_reg(CSR_SEGMENT_COUNT, 16'($urandom_range(3, 40)));
            write_reg(CSR_RING_COUNT, 16'($urandom_range(2, 40)));
         end
         random_vertices(110);
         drain();
      end

      if (fail_count == 0) $display("PASS uv_sphere_vertex_gen_top");
      else $display("FAIL uv_sphere_vertex_gen_top");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
sv/uvs_pkg.sv
sv/uvs_angle.sv
sv/uv_sphere_vertex_gen_top.sv
verif/uvs_checker.sv
verif/testbench.sv
